FILE: design/lts_pkg.sv
// lisp token scanner package: character codes, scan modes and token records
`timescale 1ns / 1ps

package lts_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_ATOM    = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_TILDE   = 3'd5
  } scan_mode_t;

  localparam logic [2:0] TK_SPECIAL = 3'd0;
  localparam logic [2:0] TK_PAIR    = 3'd1;
  localparam logic [2:0] TK_STRING  = 3'd2;
  localparam logic [2:0] TK_ATOM    = 3'd3;
  localparam logic [2:0] TK_ERROR   = 3'd4;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
  } token_t;

  // one queue entry holds every token that a single item produces
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

  function automatic logic is_special(input logic [7:0] c);
    return c == CH_LBRACKET || c == CH_RBRACKET || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_APOS || c == CH_BACKTICK ||
           c == CH_CARET || c == CH_AT;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_NEWLINE ||
           c == CH_LBRACKET || c == CH_RBRACKET || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_APOS || c == CH_QUOTE ||
           c == CH_BACKTICK || c == CH_COMMA || c == CH_SEMI;
  endfunction

endpackage

FILE: design/lisp_token_scanner.sv
// lisp token scanner top level: front end, entry queue and output stage
//
//   port group                      dir   role
//   char_valid/char_ready           in    source items: kind, char_code
//   token_valid/token_ready         out   token items: token_kind, start_offset,
//                                         token_length, line_number, last_of_run
//
// one character item per clock while char_ready is high; an item that ends one token and starts a special
// gives two token items, sent one after the other by the output stage
// first token passes through the entry queue and the output register after its character is taken
// char_ready drops only while the entry queue is full
// synchronous reset returns to idle scan, offset 0, line 1, empty queue
`timescale 1ns / 1ps

module lisp_token_scanner #(
  parameter int OFFSET_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic        kind,
  input  logic [7:0]  char_code,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] token_length,
  output logic [15:0] line_number,
  output logic        last_of_run
);

  lts_pkg::entry_t push_entry, head;
  lts_pkg::token_t token_out;
  logic            push_valid, queue_full, queue_empty, pop;

  lts_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .kind      (kind),
    .char_code (char_code),
    .queue_full(queue_full),
    .push_valid(push_valid),
    .push_entry(push_entry)
  );

  lts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  lts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (queue_empty),
    .pop        (pop),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_out  (token_out),
    .token_last (last_of_run)
  );

  assign token_kind   = token_out.kind;
  assign start_offset = token_out.start;
  assign token_length = token_out.length;
  assign line_number  = token_out.line;

endmodule

FILE: design/lts_front.sv
// scanner front end: takes characters, tracks scan state, builds token entries
`timescale 1ns / 1ps

module lts_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_ready,
  input  logic            kind,
  input  logic [7:0]      char_code,
  input  logic            queue_full,
  output logic            push_valid,
  output lts_pkg::entry_t push_entry
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  lts_pkg::scan_mode_t    mode, mode_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [OFFSET_BITS-1:0] current_offset;
  logic [15:0]            line_count, line_next;

  logic                   accept;
  logic [OFFSET_BITS-1:0] pos, pos_next, start_after;
  logic                   line_inc;
  logic                   first_hit, idle_hit, do_idle;
  logic [2:0]             first_kind;
  logic [OFFSET_BITS-1:0] first_stop;
  lts_pkg::token_t        tok_a, tok_b;

  function automatic lts_pkg::token_t make_token(input logic [2:0] tk,
                                                 input logic [OFFSET_BITS-1:0] start,
                                                 input logic [OFFSET_BITS-1:0] stop,
                                                 input logic [15:0] line);
    lts_pkg::token_t        t;
    logic [OFFSET_BITS-1:0] diff;
    diff = (stop >= start) ? stop - start : '0;
    t.kind   = tk;
    t.start  = 16'(start);
    t.length = (32'(diff) > 32'd65535) ? 16'hFFFF : 16'(diff);
    t.line   = line;
    return t;
  endfunction

  assign char_ready  = !queue_full;
  assign accept      = char_valid && !queue_full;
  assign pos         = current_offset;
  assign pos_next    = (pos == OFFSET_MAX) ? pos : pos + 1'b1;
  assign start_after = (token_start == OFFSET_MAX) ? token_start : token_start + 1'b1;

  always_comb begin
    mode_next        = mode;
    token_start_next = token_start;
    line_inc         = 1'b0;
    first_hit        = 1'b0;
    first_kind       = lts_pkg::TK_ATOM;
    first_stop       = pos;
    do_idle          = 1'b0;
    idle_hit         = 1'b0;

    if (kind == lts_pkg::KIND_EOS) begin
      case (mode)
        lts_pkg::MODE_ATOM: begin
          first_hit = 1'b1;
        end
        lts_pkg::MODE_TILDE: begin
          first_hit  = 1'b1;
          first_kind = lts_pkg::TK_SPECIAL;
          first_stop = start_after;
        end
        lts_pkg::MODE_STRING, lts_pkg::MODE_ESCAPE: begin
          first_hit  = 1'b1;
          first_kind = lts_pkg::TK_ERROR;
        end
        default: begin
        end
      endcase
    end else begin
      case (mode)
        lts_pkg::MODE_COMMENT: begin
          if (char_code == lts_pkg::CH_NEWLINE) begin
            line_inc  = 1'b1;
            mode_next = lts_pkg::MODE_IDLE;
          end
        end
        lts_pkg::MODE_ATOM: begin
          if (lts_pkg::is_delim(char_code)) begin
            first_hit = 1'b1;
            do_idle   = 1'b1;
          end
        end
        lts_pkg::MODE_TILDE: begin
          first_hit = 1'b1;
          if (char_code == lts_pkg::CH_AT) begin
            first_kind = lts_pkg::TK_PAIR;
            first_stop = pos_next;
            mode_next  = lts_pkg::MODE_IDLE;
          end else begin
            first_kind = lts_pkg::TK_SPECIAL;
            do_idle    = 1'b1;
          end
        end
        lts_pkg::MODE_STRING, lts_pkg::MODE_ESCAPE: begin
          if (mode == lts_pkg::MODE_ESCAPE &&
              (char_code == lts_pkg::CH_BACKSLASH || char_code == lts_pkg::CH_QUOTE)) begin
            mode_next = lts_pkg::MODE_STRING;
          end else if (char_code == lts_pkg::CH_QUOTE) begin
            first_hit  = 1'b1;
            first_kind = lts_pkg::TK_STRING;
            first_stop = pos_next;
            mode_next  = lts_pkg::MODE_IDLE;
          end else if (char_code == lts_pkg::CH_BACKSLASH) begin
            mode_next = lts_pkg::MODE_ESCAPE;
          end else begin
            line_inc  = (char_code == lts_pkg::CH_NEWLINE);
            mode_next = lts_pkg::MODE_STRING;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // byte handled as if it arrived with nothing open
      if (do_idle) begin
        mode_next = lts_pkg::MODE_IDLE;
        if (char_code == lts_pkg::CH_SPACE || char_code == lts_pkg::CH_CR ||
            char_code == lts_pkg::CH_TAB || char_code == lts_pkg::CH_COMMA) begin
          mode_next = lts_pkg::MODE_IDLE;
        end else if (char_code == lts_pkg::CH_NEWLINE) begin
          line_inc = 1'b1;
        end else if (char_code == lts_pkg::CH_SEMI) begin
          mode_next = lts_pkg::MODE_COMMENT;
        end else if (char_code == lts_pkg::CH_TILDE) begin
          token_start_next = pos;
          mode_next        = lts_pkg::MODE_TILDE;
        end else if (lts_pkg::is_special(char_code)) begin
          idle_hit = 1'b1;
        end else if (char_code == lts_pkg::CH_QUOTE) begin
          token_start_next = pos;
          mode_next        = lts_pkg::MODE_STRING;
        end else begin
          token_start_next = pos;
          mode_next        = lts_pkg::MODE_ATOM;
        end
      end
    end
  end

  assign line_next = (line_inc && line_count != lts_pkg::LINE_MAX) ? line_count + 16'd1
                                                                   : line_count;

  assign tok_a = make_token(first_kind, token_start, first_stop, line_count);
  assign tok_b = make_token(lts_pkg::TK_SPECIAL, pos, pos_next, line_count);

  assign push_valid        = accept && (first_hit || idle_hit);
  assign push_entry.first  = first_hit ? tok_a : tok_b;
  assign push_entry.second = tok_b;
  assign push_entry.two    = first_hit && idle_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lts_pkg::MODE_IDLE;
      token_start    <= '0;
      current_offset <= '0;
      line_count     <= 16'd1;
    end else if (accept) begin
      if (kind == lts_pkg::KIND_EOS) begin
        mode           <= lts_pkg::MODE_IDLE;
        token_start    <= '0;
        current_offset <= '0;
        line_count     <= 16'd1;
      end else begin
        mode           <= mode_next;
        token_start    <= token_start_next;
        current_offset <= pos_next;
        line_count     <= line_next;
      end
    end
  end

endmodule

FILE: design/lts_queue.sv
// short queue of token entries between scanner front end and output stage
`timescale 1ns / 1ps

module lts_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lts_pkg::entry_t push_entry,
  input  logic            pop,
  output lts_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lts_pkg::entry_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/lts_back.sv
// output stage: splits queue entries into single tokens and holds the output register
`timescale 1ns / 1ps

module lts_back (
  input  logic            clk,
  input  logic            rst,
  input  lts_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            token_valid,
  input  logic            token_ready,
  output lts_pkg::token_t token_out,
  output logic            token_last
);

  logic phase;
  logic out_free, load;

  assign out_free = !token_valid || token_ready;
  assign load     = out_free && !empty;
  // an entry leaves the queue once its last token is loaded
  assign pop      = load && (phase || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      phase       <= 1'b0;
    end else if (out_free) begin
      token_valid <= !empty;
      if (load) begin
        phase <= !pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_out  <= phase ? head.second : head.first;
      token_last <= phase || !head.two;
    end
  end

endmodule
